/* rtl/core/dcl_pkg.sv */
// Shared types, codes and Huffman tree tables for the DCL explode decoder.
package dcl_pkg;

  localparam int WindowDepthDefault = 4096;
  localparam int BitBufferBits      = 32;
  localparam int LenNodes           = 31;
  localparam int DistNodes          = 127;
  localparam logic [9:0] EndLength  = 10'd519;

  // Command codes
  typedef enum logic [1:0] {
    FN_PUSH  = 2'd0,
    FN_PULL  = 2'd1,
    FN_START = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  // Response codes
  typedef enum logic [2:0] {
    ST_BYTE      = 3'd0,
    ST_ACCEPTED  = 3'd1,
    ST_REFUSED   = 3'd2,
    ST_NEED      = 3'd3,
    ST_FINISHED  = 3'd4,
    ST_SHORT     = 3'd5,
    ST_BAD_HDR   = 3'd6
  } status_t;

  // Header progress
  typedef enum logic [1:0] {
    HDR_MODE = 2'd0,
    HDR_TYPE = 2'd1,
    HDR_RUN  = 2'd2,
    HDR_BAD  = 2'd3
  } hdr_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR,
    S_CHK,
    S_TOK,
    S_LEN,
    S_DIST,
    S_CPY,
    S_RD,
    S_EMIT,
    S_RESP
  } state_t;

  // Tree node: inner node has children lo (bit 1) and hi (bit 0);
  // a leaf keeps its symbol in hi.
  typedef struct packed {
    logic       leaf;
    logic [6:0] lo;
    logic [6:0] hi;
  } node_t;

  function automatic node_t tn(int l, int r);
    node_t n;
    n.leaf = 1'b0;
    n.lo   = 7'(r);
    n.hi   = 7'(l);
    return n;
  endfunction

  function automatic node_t tl(int v);
    node_t n;
    n.leaf = 1'b1;
    n.lo   = 7'd0;
    n.hi   = 7'(v);
    return n;
  endfunction

  // Length code tree
  localparam node_t LEN_TREE [LenNodes] = '{
    tn(1,2), tn(3,4), tn(5,6), tn(7,8), tn(9,10), tn(11,12), tl(1),
    tn(13,14), tn(15,16), tn(17,18), tl(3), tl(2), tl(0),
    tn(19,20), tn(21,22), tn(23,24), tl(6), tl(5), tl(4),
    tn(25,26), tn(27,28), tl(10), tl(9), tl(8), tl(7),
    tn(29,30), tl(13), tl(12), tl(11), tl(15), tl(14)
  };

  // Distance code tree
  localparam node_t DIST_TREE [DistNodes] = '{
    tn(1,2), tn(3,4), tn(5,6), tn(7,8), tn(9,10), tn(11,12), tl(0),
    tn(13,14), tn(15,16), tn(17,18), tn(19,20), tn(21,22), tn(23,24),
    tn(25,26), tn(27,28), tn(29,30), tn(31,32),
    tn(33,34), tn(35,36), tn(37,38), tn(39,40),
    tn(41,42), tn(43,44), tl(2), tl(1),
    tn(45,46), tn(47,48), tn(49,50), tn(51,52),
    tn(53,54), tn(55,56), tn(57,58), tn(59,60),
    tn(61,62), tn(63,64), tn(65,66), tn(67,68),
    tn(69,70), tn(71,72), tn(73,74), tn(75,76),
    tl(6), tl(5), tl(4), tl(3),
    tn(77,78), tn(79,80), tn(81,82), tn(83,84),
    tn(85,86), tn(87,88), tn(89,90), tn(91,92),
    tn(93,94), tn(95,96), tn(97,98), tn(99,100),
    tn(101,102), tn(103,104), tn(105,106), tn(107,108),
    tn(109,110), tl(21), tl(20), tl(19),
    tl(18), tl(17), tl(16), tl(15),
    tl(14), tl(13), tl(12), tl(11),
    tl(10), tl(9), tl(8), tl(7),
    tn(111,112), tn(113,114), tn(115,116), tn(117,118),
    tn(119,120), tn(121,122), tn(123,124), tn(125,126),
    tl(47), tl(46), tl(45), tl(44),
    tl(43), tl(42), tl(41), tl(40),
    tl(39), tl(38), tl(37), tl(36),
    tl(35), tl(34), tl(33), tl(32),
    tl(31), tl(30), tl(29), tl(28),
    tl(27), tl(26), tl(25), tl(24),
    tl(23), tl(22), tl(63), tl(62),
    tl(61), tl(60), tl(59), tl(58),
    tl(57), tl(56), tl(55), tl(54),
    tl(53), tl(52), tl(51), tl(50),
    tl(49), tl(48)
  };

endpackage

/* rtl/core/dcl_if.sv */
// Valid/ready channel interfaces for decoder commands and responses.
interface dcl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] in_byte;
  modport source (output valid, func, in_byte, input ready);
  modport sink (input valid, func, in_byte, output ready);
endinterface

interface dcl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_byte;
  modport source (output valid, status, out_byte, input ready);
  modport sink (input valid, status, out_byte, output ready);
endinterface

/* rtl/core/dcl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/dcl_explode_decoder_core.sv */
// Top level of the DCL explode (binary mode) streaming decoder.
// Usage:
//   cmd channel carries one command item: push a compressed byte, pull one
//   decoded byte, or start a new stream. rsp channel returns exactly one
//   item (status, out_byte) per command, in order.
//   cfg_we/cfg_data write the expected output size (0 = run to end code);
//   write it only while no command is in flight.
// Sequence: push, start and refused commands go from idle straight to the
//   response state. A pull decodes the token one Huffman tree bit per
//   cycle plus a step at each leaf; a match then reads the window RAM
//   (registered read), and each emitted byte is written back.
// Throughput: one command at a time; copy bytes pass S_CPY, S_RD, S_EMIT.
// Reset: clears the stream state and the size register. The window is
//   not swept; a fill count marks which entries the current stream has
//   written; unwritten ones read as zero. Start clears the stream state.
// Stall: the response sits in an output register; a new command is taken
//   while it waits, and its own response holds until the register frees.
module dcl_explode_decoder_core #(
  parameter int WINDOW_DEPTH = dcl_pkg::WindowDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  dcl_in_if.sink      cmd,
  dcl_out_if.source   rsp
);
  import dcl_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int BB = BitBufferBits;

  state_t          state, state_next;
  hdr_t            hstage, hstage_next;
  logic [2:0]      kind, kind_next;
  logic [BB-1:0]   bbuf, bbuf_next;
  logic [5:0]      bcnt, bcnt_next;
  logic [BB-1:0]   cbuf, cbuf_next;
  logic [5:0]      ccnt, ccnt_next;
  logic [6:0]      node, node_next;
  logic [9:0]      len, len_next;
  logic [AW-1:0]   wp, wp_next;
  logic [AW-1:0]   cs, cs_next;
  logic [9:0]      crem, crem_next;
  logic [31:0]     bw, bw_next;
  logic            fin, fin_next;
  logic [31:0]     exp_size;
  logic [7:0]      byte_r, byte_r_next;
  logic            rd_ok, rd_ok_next;
  status_t         res, res_next;
  logic            out_valid;
  logic [2:0]      out_status;
  logic [7:0]      out_byte;

  logic            acc, out_free, hdr_short, type_bad, exp_hit, finish_full;
  logic [7:0]      hdr_byte;
  logic [AW-1:0]   m;
  node_t           len_e, dist_e;
  logic [3:0]      xn;
  logic            x_short;
  logic [7:0]      xbits;
  logic [9:0]      len_val;
  logic [12:0]     dist_val;
  logic [AW-1:0]   src;
  logic [31:0]     remain;
  logic [9:0]      len_fit;
  logic            ram_we;
  logic [7:0]      ram_rdata;

  // Shared decode terms
  assign acc         = cmd.valid && cmd.ready;
  assign out_free    = !out_valid || rsp.ready;
  assign hdr_byte    = bbuf[7:0];
  assign hdr_short   = bcnt < 6'd8;
  assign type_bad    = hdr_byte < 8'd4 || hdr_byte > 8'd6 ||
                       (1 << (int'(hdr_byte[2:0]) + 6)) > WINDOW_DEPTH;
  assign exp_hit     = exp_size != 32'd0 && bw >= exp_size;
  assign finish_full = exp_size == 32'd0 || bw == exp_size;
  assign m           = AW'((32'd1 << (32'(kind) + 32'd6)) - 32'd1);
  assign len_e       = LEN_TREE[node[4:0]];
  assign dist_e      = DIST_TREE[node];
  assign xn          = (state == S_LEN) ? (len_e.hi[3:0] - 4'd7) :
                       ((len == 10'd2) ? 4'd2 : {1'b0, kind});
  assign x_short     = ccnt < {2'b00, xn};
  assign xbits       = 8'(cbuf & ((32'd1 << xn) - 32'd1));
  assign len_val     = 10'd8 + (10'd1 << xn) + {2'b00, xbits};
  assign dist_val    = ((13'(dist_e.hi) << xn) | {5'd0, xbits}) + 13'd1;
  assign src         = AW'(13'(wp) - dist_val) & m;
  assign remain      = exp_size - bw;
  assign len_fit     = (exp_size != 32'd0 && {22'd0, len} > remain) ?
                       remain[9:0] : len;
  assign cmd.ready   = state == S_IDLE;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          if (func_t'(cmd.func) == FN_PULL) begin
            if (hstage == HDR_BAD) state_next = S_RESP;
            else if (hstage == HDR_RUN) state_next = S_CHK;
            else state_next = S_HDR;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_HDR: begin
        if (hdr_short) state_next = S_RESP;
        else if (hstage == HDR_MODE) state_next = (hdr_byte != 8'd0) ? S_RESP : S_HDR;
        else state_next = type_bad ? S_RESP : S_CHK;
      end
      S_CHK: begin
        if (fin || exp_hit) state_next = S_RESP;
        else if (crem != 10'd0) state_next = S_CPY;
        else state_next = S_TOK;
      end
      S_TOK: begin
        if (ccnt == 6'd0) state_next = S_RESP;
        else if (!cbuf[0]) state_next = (ccnt < 6'd9) ? S_RESP : S_EMIT;
        else state_next = S_LEN;
      end
      S_LEN: begin
        if (len_e.leaf) begin
          if (len_e.hi < 7'd8) state_next = S_DIST;
          else if (x_short || len_val == EndLength) state_next = S_RESP;
          else state_next = S_DIST;
        end else begin
          state_next = (ccnt == 6'd0) ? S_RESP : S_LEN;
        end
      end
      S_DIST: begin
        if (dist_e.leaf) state_next = x_short ? S_RESP : S_CPY;
        else state_next = (ccnt == 6'd0) ? S_RESP : S_DIST;
      end
      S_CPY:  state_next = S_RD;
      S_RD:   state_next = S_EMIT;
      S_EMIT: state_next = S_RESP;
      S_RESP: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    hstage_next = hstage;
    kind_next   = kind;
    bbuf_next   = bbuf;
    bcnt_next   = bcnt;
    cbuf_next   = cbuf;
    ccnt_next   = ccnt;
    node_next   = node;
    len_next    = len;
    wp_next     = wp;
    cs_next     = cs;
    crem_next   = crem;
    bw_next     = bw;
    fin_next    = fin;
    byte_r_next = byte_r;
    rd_ok_next  = rd_ok;
    res_next    = res;
    ram_we      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (func_t'(cmd.func))
            FN_PUSH: begin
              if (bcnt > 6'd24) begin
                res_next = ST_REFUSED;
              end else begin
                bbuf_next = bbuf | (BB'(cmd.in_byte) << bcnt[4:0]);
                bcnt_next = bcnt + 6'd8;
                res_next  = ST_ACCEPTED;
              end
            end
            FN_START: begin
              bbuf_next   = '0;
              bcnt_next   = '0;
              hstage_next = HDR_MODE;
              kind_next   = '0;
              wp_next     = '0;
              cs_next     = '0;
              crem_next   = '0;
              bw_next     = '0;
              fin_next    = 1'b0;
              res_next    = ST_ACCEPTED;
            end
            FN_PULL: res_next = ST_BAD_HDR;
            FN_NONE: res_next = ST_REFUSED;
            default: res_next = ST_REFUSED;
          endcase
        end
      end
      // Header bytes commit as they are read
      S_HDR: begin
        if (hdr_short) begin
          res_next = ST_NEED;
        end else begin
          bbuf_next = bbuf >> 8;
          bcnt_next = bcnt - 6'd8;
          if (hstage == HDR_MODE) begin
            if (hdr_byte != 8'd0) begin
              hstage_next = HDR_BAD;
              res_next    = ST_BAD_HDR;
            end else begin
              hstage_next = HDR_TYPE;
            end
          end else if (type_bad) begin
            hstage_next = HDR_BAD;
            res_next    = ST_BAD_HDR;
          end else begin
            kind_next   = hdr_byte[2:0];
            hstage_next = HDR_RUN;
          end
        end
      end
      S_CHK: begin
        if (fin || exp_hit) begin
          fin_next = 1'b1;
          res_next = finish_full ? ST_FINISHED : ST_SHORT;
        end else begin
          cbuf_next = bbuf;
          ccnt_next = bcnt;
        end
      end
      // Token flag bit; a literal commits right away
      S_TOK: begin
        if (ccnt == 6'd0) begin
          res_next = ST_NEED;
        end else if (!cbuf[0]) begin
          if (ccnt < 6'd9) begin
            res_next = ST_NEED;
          end else begin
            byte_r_next = cbuf[8:1];
            bbuf_next   = cbuf >> 9;
            bcnt_next   = ccnt - 6'd9;
          end
        end else begin
          cbuf_next = cbuf >> 1;
          ccnt_next = ccnt - 6'd1;
          node_next = '0;
        end
      end
      // One length tree level per cycle
      S_LEN: begin
        if (len_e.leaf) begin
          node_next = '0;
          if (len_e.hi < 7'd8) begin
            len_next = 10'(len_e.hi) + 10'd2;
          end else if (x_short) begin
            res_next = ST_NEED;
          end else begin
            len_next  = len_val;
            cbuf_next = cbuf >> xn;
            ccnt_next = ccnt - 6'(xn);
            if (len_val == EndLength) begin
              bbuf_next = cbuf >> xn;
              bcnt_next = ccnt - 6'(xn);
              fin_next  = 1'b1;
              res_next  = finish_full ? ST_FINISHED : ST_SHORT;
            end
          end
        end else if (ccnt == 6'd0) begin
          res_next = ST_NEED;
        end else begin
          node_next = cbuf[0] ? len_e.lo : len_e.hi;
          cbuf_next = cbuf >> 1;
          ccnt_next = ccnt - 6'd1;
        end
      end
      // One distance tree level per cycle, then commit the match
      S_DIST: begin
        if (dist_e.leaf) begin
          if (x_short) begin
            res_next = ST_NEED;
          end else begin
            bbuf_next = cbuf >> xn;
            bcnt_next = ccnt - 6'(xn);
            cs_next   = src;
            crem_next = len_fit;
          end
        end else if (ccnt == 6'd0) begin
          res_next = ST_NEED;
        end else begin
          node_next = cbuf[0] ? dist_e.lo : dist_e.hi;
          cbuf_next = cbuf >> 1;
          ccnt_next = ccnt - 6'd1;
        end
      end
      // Window read; entries past the fill count read as zero
      S_CPY: begin
        rd_ok_next = bw > {{(32-AW){1'b0}}, m} || {{(32-AW){1'b0}}, cs} < bw;
        cs_next    = (cs + AW'(1)) & m;
        crem_next  = crem - 10'd1;
      end
      S_RD: byte_r_next = rd_ok ? ram_rdata : 8'd0;
      S_EMIT: begin
        ram_we   = 1'b1;
        wp_next  = (wp + AW'(1)) & m;
        bw_next  = bw + 32'd1;
        res_next = ST_BYTE;
      end
      S_RESP: ;
      default: ;
    endcase
  end

  // Window store
  dcl_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp & m),
    .wdata (byte_r),
    .raddr (cs & m),
    .rdata (ram_rdata)
  );

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hstage    <= HDR_MODE;
      kind      <= '0;
      bbuf      <= '0;
      bcnt      <= '0;
      wp        <= '0;
      cs        <= '0;
      crem      <= '0;
      bw        <= '0;
      fin       <= 1'b0;
      exp_size  <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      hstage <= hstage_next;
      kind   <= kind_next;
      bbuf   <= bbuf_next;
      bcnt   <= bcnt_next;
      wp     <= wp_next;
      cs     <= cs_next;
      crem   <= crem_next;
      bw     <= bw_next;
      fin    <= fin_next;
      if (cfg_we) exp_size <= cfg_data;
      if (state == S_RESP && out_free) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cbuf   <= cbuf_next;
    ccnt   <= ccnt_next;
    node   <= node_next;
    len    <= len_next;
    byte_r <= byte_r_next;
    rd_ok  <= rd_ok_next;
    res    <= res_next;
    if (state == S_RESP && out_free) begin
      out_status <= res;
      out_byte   <= (res == ST_BYTE) ? byte_r : 8'd0;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.out_byte = out_byte;

  // Checks
  a_bcnt_range: assert property (@(posedge clk) disable iff (rst)
    bcnt <= 6'd32) else $error("bit count overflow");
  a_rd_after_cpy: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> $past(state) == S_CPY) else $error("read without issue");
  a_copy_running: assert property (@(posedge clk) disable iff (rst)
    crem != 10'd0 |-> hstage == HDR_RUN) else $error("copy outside stream");
  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |=> state == S_RESP) else $error("emit sequencing");
endmodule
